// ===== sv/vpv_pkg.sv =====
package vpv_pkg;

    // Shared long-division pipeline geometry
    localparam int DIV_NW  = 64;          // dividend magnitude bits
    localparam int DIV_DW  = 32;          // divisor magnitude bits
    localparam int DIV_QB  = 33;          // quotient bits resolved, one per stage
    localparam int DIV_LAT = DIV_QB + 2;  // range check + steps + clamp

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_PROJECT = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_W_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    localparam logic [2:0] CFG_VP_X      = 3'd0;
    localparam logic [2:0] CFG_VP_Y      = 3'd1;
    localparam logic [2:0] CFG_VP_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_VP_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_NEAR      = 3'd4;
    localparam logic [2:0] CFG_FAR       = 3'd5;

    typedef struct packed {
        logic [DIV_NW-1:0] n_mag;
        logic [DIV_DW-1:0] d_mag;
        logic              neg;
    } div_req_t;

    typedef struct packed {
        logic signed [31:0] quo;
        logic               sat;
    } div_rsp_t;

endpackage

// ===== sv/vpv_div_pipe.sv =====
module vpv_div_pipe
    import vpv_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_NW-1:0] r_reg   [0:DIV_QB];
    logic [DIV_QB-1:0] q_reg   [0:DIV_QB];
    logic [DIV_DW-1:0] d_reg   [0:DIV_QB];
    logic [DIV_QB:0]   neg_reg;
    logic [DIV_QB:0]   ovf_reg;
    div_rsp_t          rsp_reg;

    logic [DIV_QB-1:0] q_fin;
    logic              over;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient must fit the resolved bits, else it saturates anyway
            r_reg[0]   <= req.n_mag;
            q_reg[0]   <= '0;
            d_reg[0]   <= req.d_mag;
            neg_reg[0] <= req.neg;
            ovf_reg[0] <= (req.n_mag >> DIV_QB) >= DIV_NW'(req.d_mag);
            for (int k = 1; k <= DIV_QB; k++)
            begin
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                if (r_reg[k-1] >= (DIV_NW'(d_reg[k-1]) << (DIV_QB - k)))
                begin
                    r_reg[k] <= r_reg[k-1] - (DIV_NW'(d_reg[k-1]) << (DIV_QB - k));
                    q_reg[k] <= q_reg[k-1] | (DIV_QB'(1) << (DIV_QB - k));
                end
                else
                begin
                    r_reg[k] <= r_reg[k-1];
                    q_reg[k] <= q_reg[k-1];
                end
            end
            rsp_reg.sat <= over;
            if (over)
                rsp_reg.quo <= neg_reg[DIV_QB] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            else if (neg_reg[DIV_QB])
                rsp_reg.quo <= 32'(-q_fin);
            else
                rsp_reg.quo <= q_fin[31:0];
        end
    end

    assign q_fin = q_reg[DIV_QB];
    assign over  = ovf_reg[DIV_QB]
                || (q_fin > ({2'b00, 31'h7fff_ffff} + DIV_QB'(neg_reg[DIV_QB])));

    assign rsp = rsp_reg;

endmodule

// ===== sv/vertex_project_to_viewport_unit.sv =====
// Vertex projection to viewport coordinates, signed fixed point.
// Input channel (in_valid/in_ready): a request with kind load writes one of
// 32 matrix coefficients (0-15 model-view, 16-31 projection, column-major)
// and gives no result; a request with kind project gives one result.
// Output channel (out_valid/out_ready): image_x, image_y, depth_value, status.
// Configuration (cfg_write/cfg_index/cfg_data) sets the viewport and the
// near and far planes; write it only while no request is in flight.
// Throughput: one request per cycle while the output is not stalled. A request
// passes five front stages (input, multiply, sum, multiply, sum), then two chained
// 35-stage long-division pipelines (x/w, y/w and depth terms, then the depth divide
// by -clip z), then the viewport-map register and the output register.
// Loads take effect in request order: a load reaches its matrix bank at the
// stage that reads that bank, so later projects see it and earlier do not.
// Reset clears the coefficients, the viewport, and sets near 10.0, far 200.0.
// The pipeline moves as one: when out_valid is high and out_ready low every
// stage holds and in_ready drops; nothing is lost or repeated.
module vertex_project_to_viewport_unit
    import vpv_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [4:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] image_x,
    output logic signed [31:0] image_y,
    output logic signed [31:0] depth_value,
    output logic [1:0]         status
);

    localparam logic signed [32:0] FX_ONE     = 33'(1 << FRAC_BITS);
    localparam logic signed [31:0] FX_NEG_ONE = 32'(-(1 << FRAC_BITS));

    typedef struct packed {
        logic               sat;
        logic               w_zero;
        logic               d_zero;
        logic signed [32:0] vz;
    } side1_t;

    typedef struct packed {
        logic               sat;
        logic               w_zero;
        logic               d_zero;
        logic               vz_zero;
        logic               a_nonneg;
        logic signed [31:0] t1;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
    } side2_t;

    function automatic logic [32:0] clamp32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return {1'b1, 32'h7fff_ffff};
        else if (v < -66'sd2147483648)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, v[31:0]};
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    logic en;

    // configuration
    logic [15:0]        vx_reg, vy_reg, vw_reg, vh_reg;
    logic [30:0]        near_reg, far_reg;
    logic [61:0]        fn_prod;
    logic [63:0]        fn2_reg;
    logic signed [31:0] dlt_reg;
    logic [31:0]        nfsum_reg;

    // coefficient banks
    logic signed [31:0] mv_reg [16];
    logic signed [31:0] pj_reg [16];

    // front stages
    logic               s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    logic               s1_kind_reg, s2_kind_reg, s3_kind_reg;
    logic [4:0]         s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic signed [31:0] s1_val_reg, s2_val_reg, s3_val_reg;
    logic signed [31:0] s1_pt_reg [3];
    logic signed [31:0] pt [4];
    logic signed [63:0] s2_prod_reg [4][4];
    logic signed [63:0] s4_prod_reg [4][4];
    logic signed [31:0] s3_eye_reg [4];
    logic signed [31:0] s5_clip_reg [4];
    logic               s3_sat_reg, s4_sat_reg, s5_sat_reg;
    logic signed [31:0] eye_next  [4];
    logic signed [31:0] clip_next [4];
    logic               eye_sat_next, clip_sat_next;

    // division stages
    div_req_t div_x_req, div_y_req, div_t1_req, div_a_req, div_t2_req;
    div_rsp_t div_x_rsp, div_y_rsp, div_t1_rsp, div_a_rsp, div_t2_rsp;
    logic [DIV_LAT-1:0] dv1_reg, dv2_reg;
    side1_t             ds1_reg [DIV_LAT];
    side2_t             ds2_reg [DIV_LAT];
    side1_t             side1_next, side1_out;
    side2_t             side2_next, side2_out;

    // tail
    logic               h_v_reg;
    side2_t             h_side_reg;
    logic               h_sat_reg;
    logic signed [49:0] hx_reg, hy_reg;
    logic signed [32:0] hd_reg;
    logic signed [65:0] ix_wide, iy_wide;
    logic [32:0]        ix_c, iy_c, dep_c;
    logic               out_valid_reg;
    logic signed [31:0] image_x_reg, image_y_reg, depth_reg;
    logic [1:0]         status_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg   <= '0;
            vy_reg   <= '0;
            vw_reg   <= '0;
            vh_reg   <= '0;
            near_reg <= 31'd655360;
            far_reg  <= 31'd13107200;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_VP_X:      vx_reg   <= cfg_data[15:0];
                CFG_VP_Y:      vy_reg   <= cfg_data[15:0];
                CFG_VP_WIDTH:  vw_reg   <= cfg_data[15:0];
                CFG_VP_HEIGHT: vh_reg   <= cfg_data[15:0];
                CFG_NEAR:      near_reg <= cfg_data;
                CFG_FAR:       far_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign fn_prod = near_reg * far_reg;

    // plane-derived terms follow the plane registers in the next cycle
    always_ff @(posedge clk)
    begin
        fn2_reg   <= {1'b0, fn_prod, 1'b0};
        dlt_reg   <= {1'b0, far_reg} - {1'b0, near_reg};
        nfsum_reg <= {1'b0, far_reg} + {1'b0, near_reg};
    end

    // ---------------- coefficient banks ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                mv_reg[i] <= '0;
                pj_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            if (s1_v_reg && s1_kind_reg == KIND_LOAD && !s1_idx_reg[4])
                mv_reg[s1_idx_reg[3:0]] <= s1_val_reg;
            if (s3_v_reg && s3_kind_reg == KIND_LOAD && s3_idx_reg[4])
                pj_reg[s3_idx_reg[3:0]] <= s3_val_reg;
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            dv1_reg       <= '0;
            dv2_reg       <= '0;
            h_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg      <= in_valid;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            // loads are done once they pass the projection bank
            s4_v_reg      <= s3_v_reg && s3_kind_reg == KIND_PROJECT;
            s5_v_reg      <= s4_v_reg;
            dv1_reg       <= {dv1_reg[DIV_LAT-2:0], s5_v_reg};
            dv2_reg       <= {dv2_reg[DIV_LAT-2:0], dv1_reg[DIV_LAT-1]};
            h_v_reg       <= dv2_reg[DIV_LAT-1];
            out_valid_reg <= h_v_reg;
        end
    end

    // ---------------- matrix stages ----------------
    assign pt[0] = s1_pt_reg[0];
    assign pt[1] = s1_pt_reg[1];
    assign pt[2] = s1_pt_reg[2];
    assign pt[3] = FX_ONE[31:0];

    always_comb
    begin
        logic signed [65:0] acc;
        logic [32:0]        c;
        eye_sat_next  = s2_kind_reg == KIND_LOAD;
        clip_sat_next = 1'b0;
        eye_sat_next  = 1'b0;
        for (int r = 0; r < 4; r++)
        begin
            acc = 66'(s2_prod_reg[r][0]) + 66'(s2_prod_reg[r][1])
                + 66'(s2_prod_reg[r][2]) + 66'(s2_prod_reg[r][3]);
            c = clamp32(acc >>> FRAC_BITS);
            eye_next[r]  = c[31:0];
            eye_sat_next = eye_sat_next | c[32];
            acc = 66'(s4_prod_reg[r][0]) + 66'(s4_prod_reg[r][1])
                + 66'(s4_prod_reg[r][2]) + 66'(s4_prod_reg[r][3]);
            c = clamp32(acc >>> FRAC_BITS);
            clip_next[r]  = c[31:0];
            clip_sat_next = clip_sat_next | c[32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_kind_reg  <= kind;
            s1_idx_reg   <= coef_index;
            s1_val_reg   <= coef_value;
            s1_pt_reg[0] <= point_x;
            s1_pt_reg[1] <= point_y;
            s1_pt_reg[2] <= point_z;

            s2_kind_reg <= s1_kind_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_val_reg  <= s1_val_reg;
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    s2_prod_reg[r][c] <= mv_reg[4'(c * 4 + r)] * pt[c];

            s3_kind_reg <= s2_kind_reg;
            s3_idx_reg  <= s2_idx_reg;
            s3_val_reg  <= s2_val_reg;
            s3_eye_reg  <= eye_next;
            s3_sat_reg  <= eye_sat_next;

            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    s4_prod_reg[r][c] <= pj_reg[4'(c * 4 + r)] * s3_eye_reg[c];
            s4_sat_reg <= s3_sat_reg;

            s5_clip_reg <= clip_next;
            s5_sat_reg  <= s4_sat_reg | clip_sat_next;
        end
    end

    // ---------------- first division pass ----------------
    always_comb
    begin
        div_x_req.n_mag  = DIV_NW'(mag32(s5_clip_reg[0])) << FRAC_BITS;
        div_x_req.d_mag  = mag32(s5_clip_reg[3]);
        div_x_req.neg    = s5_clip_reg[0][31] ^ s5_clip_reg[3][31];
        div_y_req.n_mag  = DIV_NW'(mag32(s5_clip_reg[1])) << FRAC_BITS;
        div_y_req.d_mag  = mag32(s5_clip_reg[3]);
        div_y_req.neg    = s5_clip_reg[1][31] ^ s5_clip_reg[3][31];
        div_t1_req.n_mag = DIV_NW'(nfsum_reg) << FRAC_BITS;
        div_t1_req.d_mag = mag32(dlt_reg);
        div_t1_req.neg   = dlt_reg[31];
        div_a_req.n_mag  = fn2_reg;
        div_a_req.d_mag  = mag32(dlt_reg);
        div_a_req.neg    = dlt_reg[31];

        side1_next.sat    = s5_sat_reg;
        side1_next.w_zero = s5_clip_reg[3] == '0;
        side1_next.d_zero = dlt_reg == '0;
        side1_next.vz     = -33'(s5_clip_reg[2]);
    end

    vpv_div_pipe u_div_x  (.clk(clk), .en(en), .req(div_x_req),  .rsp(div_x_rsp));
    vpv_div_pipe u_div_y  (.clk(clk), .en(en), .req(div_y_req),  .rsp(div_y_rsp));
    vpv_div_pipe u_div_t1 (.clk(clk), .en(en), .req(div_t1_req), .rsp(div_t1_rsp));
    vpv_div_pipe u_div_a  (.clk(clk), .en(en), .req(div_a_req),  .rsp(div_a_rsp));

    assign side1_out = ds1_reg[DIV_LAT-1];

    // ---------------- second division pass ----------------
    always_comb
    begin
        div_t2_req.n_mag = DIV_NW'(mag32(div_a_rsp.quo)) << FRAC_BITS;
        div_t2_req.d_mag = side1_out.vz[32] ? 32'(-side1_out.vz) : side1_out.vz[31:0];
        div_t2_req.neg   = div_a_rsp.quo[31] ^ side1_out.vz[32];

        side2_next.sat      = side1_out.sat | div_x_rsp.sat | div_y_rsp.sat
                            | div_t1_rsp.sat | div_a_rsp.sat;
        side2_next.w_zero   = side1_out.w_zero;
        side2_next.d_zero   = side1_out.d_zero;
        side2_next.vz_zero  = side1_out.vz == '0;
        side2_next.a_nonneg = !div_a_rsp.quo[31];
        side2_next.t1       = div_t1_rsp.quo;
        side2_next.nx       = div_x_rsp.quo;
        side2_next.ny       = div_y_rsp.quo;
    end

    vpv_div_pipe u_div_t2 (.clk(clk), .en(en), .req(div_t2_req), .rsp(div_t2_rsp));

    assign side2_out = ds2_reg[DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ds1_reg[0] <= side1_next;
            ds2_reg[0] <= side2_next;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                ds1_reg[k] <= ds1_reg[k-1];
                ds2_reg[k] <= ds2_reg[k-1];
            end
        end
    end

    // ---------------- viewport map and depth ----------------
    always_comb
    begin
        ix_wide = ($signed({50'b0, vx_reg}) <<< FRAC_BITS) + 66'(hx_reg >>> 1);
        iy_wide = ($signed({50'b0, vh_reg}) <<< FRAC_BITS)
                - (($signed({50'b0, vy_reg}) <<< FRAC_BITS) + 66'(hy_reg >>> 1));
        ix_c = clamp32(ix_wide);
        iy_c = clamp32(iy_wide);
        if (h_side_reg.d_zero)
            dep_c = {1'b1, 32'h7fff_ffff};
        else if (h_side_reg.vz_zero)
            dep_c = h_side_reg.a_nonneg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7fff_ffff};
        else
            dep_c = clamp32(66'(hd_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_side_reg <= side2_out;
            h_sat_reg  <= side2_out.sat | div_t2_rsp.sat;
            hx_reg     <= (33'(side2_out.nx) + FX_ONE) * $signed({1'b0, vw_reg});
            hy_reg     <= (33'(side2_out.ny) + FX_ONE) * $signed({1'b0, vh_reg});
            hd_reg     <= 33'(side2_out.t1) + 33'(div_t2_rsp.quo);

            if (h_side_reg.w_zero)
            begin
                image_x_reg <= FX_NEG_ONE;
                image_y_reg <= FX_NEG_ONE;
                depth_reg   <= FX_NEG_ONE;
                status_reg  <= ST_W_ZERO;
            end
            else
            begin
                image_x_reg <= ix_c[31:0];
                image_y_reg <= iy_c[31:0];
                depth_reg   <= dep_c[31:0];
                status_reg  <= (h_sat_reg | ix_c[32] | iy_c[32] | dep_c[32])
                             ? ST_SAT : ST_OK;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign image_x     = image_x_reg;
    assign image_y     = image_y_reg;
    assign depth_value = depth_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    a_w_zero_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_W_ZERO |->
            image_x == FX_NEG_ONE && image_y == FX_NEG_ONE && depth_value == FX_NEG_ONE)
        else $error("clip w zero result not -1");

    a_mv_load: assert property (@(posedge clk) disable iff (!rst_n)
        en && s1_v_reg && s1_kind_reg == KIND_LOAD && !s1_idx_reg[4] |=>
            mv_reg[$past(s1_idx_reg[3:0])] == $past(s1_val_reg))
        else $error("model-view load not applied");
`endif

endmodule

// ===== tb/sv/vertex_project_to_viewport_checker.sv =====
`timescale 1ns / 100ps

module vertex_project_to_viewport_checker
    import vpv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               kind,
    input  logic [4:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] image_x,
    input  logic signed [31:0] image_y,
    input  logic signed [31:0] depth_value,
    input  logic [1:0]         status,
    output int                 errors,
    output int                 pending
);

    localparam longint ONE = 64'sd65536;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] ix;
        logic signed [31:0] iy;
        logic signed [31:0] dep;
        logic [1:0]         st;
    } pixel_t;

    pixel_t             pixel_q[$];
    logic signed [31:0] coef_mem[32];
    logic [15:0]        vp_x, vp_y, vp_w, vp_h;
    logic [30:0]        near_pl, far_pl;

    function automatic longint clamp32(longint v, inout bit sat);
        if (v > I32_MAX)
        begin
            sat = 1'b1;
            return I32_MAX;
        end
        if (v < I32_MIN)
        begin
            sat = 1'b1;
            return I32_MIN;
        end
        return v;
    endfunction

    // floor on every product, fraction bits summed apart
    function automatic void mat_mul(int base, longint vin[4], output longint vout[4],
                                    inout bit sat);
        longint hi, lo, p;
        for (int r = 0; r < 4; r++)
        begin
            hi = 0;
            lo = 0;
            for (int c = 0; c < 4; c++)
            begin
                p = longint'(coef_mem[(base + c * 4 + r) & 31]) * vin[c];
                hi += p >>> 16;
                lo += p & 64'hFFFF;
            end
            vout[r] = clamp32(hi + (lo >>> 16), sat);
        end
    endfunction

    function automatic pixel_t project(longint px, longint py, longint pz);
        longint pt[4], eye[4], clip[4];
        longint nx, ny, ix, iy, dep, n, f, d, vz, t1, a, t2;
        bit     sat;
        pixel_t res;
        sat = 1'b0;
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        pt[3] = ONE;
        mat_mul(0, pt, eye, sat);
        mat_mul(16, eye, clip, sat);
        if (clip[3] == 0)
        begin
            res.ix = 32'(-ONE);
            res.iy = 32'(-ONE);
            res.dep = 32'(-ONE);
            res.st = ST_W_ZERO;
            return res;
        end
        nx = clamp32((clip[0] * ONE) / clip[3], sat);
        ny = clamp32((clip[1] * ONE) / clip[3], sat);
        ix = longint'(vp_x) * ONE + (((nx + ONE) * longint'(vp_w)) >>> 1);
        iy = longint'(vp_h) * ONE
           - (longint'(vp_y) * ONE + (((ny + ONE) * longint'(vp_h)) >>> 1));
        ix = clamp32(ix, sat);
        iy = clamp32(iy, sat);
        n = longint'(near_pl);
        f = longint'(far_pl);
        d = f - n;
        vz = -clip[2];
        if (d == 0)
        begin
            dep = I32_MAX;
            sat = 1'b1;
        end
        else
        begin
            t1 = clamp32(((n + f) * ONE) / d, sat);
            a = clamp32((2 * f * n) / d, sat);
            if (vz == 0)
            begin
                dep = (a >= 0) ? I32_MIN : I32_MAX;
                sat = 1'b1;
            end
            else
            begin
                t2 = clamp32((a * ONE) / vz, sat);
                dep = clamp32(t1 + t2, sat);
            end
        end
        res.ix = ix[31:0];
        res.iy = iy[31:0];
        res.dep = dep[31:0];
        res.st = sat ? ST_SAT : ST_OK;
        return res;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                coef_mem[i] = '0;
            vp_x = '0;
            vp_y = '0;
            vp_w = '0;
            vp_h = '0;
            near_pl = 31'd655360;
            far_pl = 31'd13107200;
            pixel_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_VP_X:      vp_x = cfg_data[15:0];
                    CFG_VP_Y:      vp_y = cfg_data[15:0];
                    CFG_VP_WIDTH:  vp_w = cfg_data[15:0];
                    CFG_VP_HEIGHT: vp_h = cfg_data[15:0];
                    CFG_NEAR:      near_pl = cfg_data;
                    CFG_FAR:       far_pl = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (kind == KIND_LOAD)
                    coef_mem[coef_index] = coef_value;
                else
                    pixel_q.insert(pixel_q.size(), project(point_x, point_y, point_z));
            end
            if (out_valid && out_ready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (image_x !== want.ix)
                        report("image_x", image_x, want.ix);
                    if (image_y !== want.iy)
                        report("image_y", image_y, want.iy);
                    if (depth_value !== want.dep)
                        report("depth_value", depth_value, want.dep);
                    if (status !== want.st)
                        report("status", 32'(status), 32'(want.st));
                end
            end
            pending = pixel_q.size();
        end
    end

endmodule

// ===== tb/sv/vertex_project_to_viewport_unit_tb.sv =====
`timescale 1ns / 100ps

module vertex_project_to_viewport_unit_tb
    import vpv_pkg::*;
();

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [30:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic [4:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] image_x;
    logic signed [31:0] image_y;
    logic signed [31:0] depth_value;
    logic [1:0]         status;
    int                 errors;
    int                 pending;

    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    localparam int ONE = 65536;

    always #1 clk = ~clk;

    vertex_project_to_viewport_unit u_dut (.*);

    vertex_project_to_viewport_checker u_chk (.*);

    function automatic logic signed [31:0] rnd_fx(int mag);
        return int'($urandom_range(2 * mag * ONE)) - mag * ONE;
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (no_idle)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 14);
    end

    task automatic send(logic k, logic [4:0] idx, logic signed [31:0] val,
                        logic signed [31:0] px, logic signed [31:0] py,
                        logic signed [31:0] pz);
        if (!no_idle && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        coef_index <= idx;
        coef_value <= val;
        point_x <= px;
        point_y <= py;
        point_z <= pz;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic load(int idx, logic signed [31:0] val);
        send(KIND_LOAD, idx[4:0], val, $urandom, $urandom, $urandom);
    endtask

    task automatic proj(logic signed [31:0] px, logic signed [31:0] py,
                        logic signed [31:0] pz);
        send(KIND_PROJECT, 5'($urandom), $urandom, px, py, pz);
    endtask

    // Drain, then let loads clear the pipe before touching the registers
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_regs(int vx, int vy, int vw, int vh, int n, int f);
        int vals[6];
        vals = '{vx, vy, vw, vh, n, f};
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i][30:0];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_camera();
        for (int i = 0; i < 16; i++)
            load(i, (i % 5 == 0) ? ONE : 0);
        for (int i = 16; i < 32; i++)
            load(i, 0);
        load(16, ONE);
        load(21, ONE);
        load(26, -ONE);
        load(27, -ONE);
        load(30, -2 * ONE);
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_VP_X;
        cfg_data <= '0;
        in_valid <= 1'b0;
        kind <= KIND_LOAD;
        coef_index <= '0;
        coef_value <= '0;
        point_x <= '0;
        point_y <= '0;
        point_z <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero matrices: clip w zero
        proj(32'sh7FFFFFFF, 32'sh80000000, 0);
        drain();
        set_regs(10, 20, 640, 480, 10 * ONE, 200 * ONE);
        load_camera();
        proj(0, 0, -5 * ONE);
        proj(ONE, -ONE, -10 * ONE);
        proj(0, 0, 0);
        proj(0, 0, -2 * ONE);
        proj(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        proj(32'sh80000000, 32'sh80000000, 32'sh80000000);
        proj(3 * ONE, 2 * ONE, -ONE);
        drain();
        set_regs(0, 0, 100, 100, 50 * ONE, 50 * ONE);
        proj(ONE, ONE, -3 * ONE);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_regs(0, 0, 0, 0, 0, 0);
                1: set_regs(65535, 65535, 65535, 65535, 0, 32'h7FFFFFFF);
                2: set_regs(100, 50, 1920, 1080, ONE / 10, 1000 * ONE);
                3: set_regs(65535, 0, 800, 600, 32'h7FFFFFFF, 32'h7FFFFFFF);
                4: set_regs(0, 65535, 320, 240, 300 * ONE, 10 * ONE);
                default: set_regs($urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(32'h7FFFFFFF),
                                  $urandom_range(32'h7FFFFFFF));
            endcase
            no_idle = (phase == 2);
            if (phase == 3)
                hold_req <= 1'b1;
            load_camera();
            k = 0;
            while (k < 160)
            begin
                if ($urandom_range(99) < 10)
                begin
                    send(1'($urandom), 5'($urandom), $urandom, $urandom, $urandom,
                         $urandom);
                    k++;
                end
                else
                begin
                    repeat ($urandom_range(0, 3))
                        load($urandom_range(31), rnd_fx($urandom_range(1, 4)));
                    repeat ($urandom_range(1, 8))
                    begin
                        proj(rnd_fx(100), rnd_fx(100), rnd_fx(100));
                        k++;
                    end
                end
            end
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/vpv_pkg.sv
sv/vpv_div_pipe.sv
sv/vertex_project_to_viewport_unit.sv
tb/sv/vertex_project_to_viewport_checker.sv
tb/sv/vertex_project_to_viewport_unit_tb.sv
